[src/least_squares_poly_fit_assert.svh]
// Assertion macros shared by the least-squares fit modules.
`ifndef LEAST_SQUARES_POLY_FIT_ASSERT_SVH
`define LEAST_SQUARES_POLY_FIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LSPF_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LSPF_ASSERT(lbl, prop, msg) `LSPF_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)
`else
`define LSPF_ASSERT_CR(lbl, clk, rstn, prop, msg)
`define LSPF_ASSERT(lbl, prop, msg)
`endif
`endif

[src/lspf_pkg.sv]
// Types, constants and saturating arithmetic for the least-squares fit.
`timescale 1ns / 1ps
package lspf_pkg;

  localparam int MaxDegreeDef  = 3;
  localparam int MaxDegreeHigh = 4;
  localparam int IdxW          = $clog2(2 * MaxDegreeHigh + 2);
  localparam logic [63:0] QOne = 64'h0000_0001_0000_0000;

  // One input word: a sample in Q8.8.
  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_point;
  } sample_t;

  // One result word: a coefficient in Q32.32.
  typedef struct packed {
    logic [1:0]         coef_index;
    logic signed [63:0] coef_value;
    logic               singular;
    logic               last_coef;
  } coef_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_ACC_P, OP_ACC_PX, OP_ACC_M, OP_SET_P, OP_BUILD,
    OP_RD_II, OP_RD_KI, OP_PIV_LD, OP_PIV_CMP, OP_SWAP, OP_SING, OP_DIV_EL,
    OP_TERM, OP_RD_IJ, OP_MUL_EL, OP_RD_KJ, OP_WR_KJ, OP_RD_IM, OP_V_LD,
    OP_MUL_BS, OP_V_SUB, OP_BS_CHK, OP_SOL, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ACC_ADD, S_ACC_WY, S_ACC_WX, S_BUILD, S_PV_RD, S_PV_LD, S_PV_RK,
    S_PV_CMP, S_SWAP, S_EL_CHK, S_EL_RK, S_EL_DIV, S_EL_WD, S_EL_RI, S_EL_MUL,
    S_EL_WM, S_EL_WR, S_BS_RD, S_BS_LV, S_BS_RJ, S_BS_MUL, S_BS_WM, S_BS_RP,
    S_BS_CHK, S_BS_WD, S_OUT
  } state_e;

  typedef struct packed {
    op_e            op;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] k;
    logic [IdxW-1:0] m;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic piv_less;
    logic rd_zero;
    logic piv_zero;
  } stat_t;

  // Magnitude of a two's complement value; the minimum maps to 2^63.
  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed range.
  function automatic logic [63:0] sat_sign(input logic [63:0] m, input logic neg);
    if (neg) begin
      return m[63] ? 64'h8000_0000_0000_0000 : (~m + 64'd1);
    end
    return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

endpackage

[src/lspf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lspf_ram #(
  parameter int Width = 64,
  parameter int Depth = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/lspf_mul.sv]
// Q32.32 multiplier built from four 32x32 partial products, rounded and saturated.
`timescale 1ns / 1ps
module lspf_mul import lspf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic         busy_q, busy_d, done_q, done_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [63:0]  ma_q, mb_q, res_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rnd;
  logic [63:0]  mag;

  // One partial product per step, placed by its weight.
  always_comb begin
    a_part = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
    b_part = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp     = a_part * b_part;
    case ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    rnd = acc_q + 128'h8000_0000;
    mag = (rnd[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : rnd[95:32];
  end

  // Step control.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= mag64(a_i);
      mb_q  <= mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        res_q <= sat_sign(mag, neg_q);
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[src/lspf_div.sv]
// Q32.32 divider, restoring, one quotient bit per cycle, saturated.
`timescale 1ns / 1ps
module lspf_div import lspf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] mb_q, rem_q, lo_q, quo_q, res_q;
  logic        neg_q;
  logic [63:0] ma, mb;
  logic        ovf;
  logic [64:0] rem_w, diff;
  logic        ge;

  // Start check and one restoring step.
  always_comb begin
    ma    = mag64(a_i);
    mb    = mag64(b_i);
    ovf   = {32'd0, ma[63:32]} >= mb;
    rem_w = {rem_q, lo_q[63]};
    diff  = rem_w - {1'b0, mb_q};
    ge    = rem_w >= {1'b0, mb_q};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = !ovf;
      done_d = ovf;
      cnt_d  = 7'd0;
    end else if (busy_q) begin
      if (cnt_q == 7'd64) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[63] ^ b_i[63];
      mb_q  <= mb;
      rem_q <= {32'd0, ma[63:32]};
      lo_q  <= {ma[31:0], 32'd0};
      quo_q <= 64'd0;
      if (ovf) begin
        res_q <= sat_sign(64'hFFFF_FFFF_FFFF_FFFF, a_i[63] ^ b_i[63]);
      end
    end else if (busy_q) begin
      if (cnt_q == 7'd64) begin
        res_q <= sat_sign(quo_q, neg_q);
      end else begin
        rem_q <= ge ? diff[63:0] : rem_w[63:0];
        lo_q  <= {lo_q[62:0], 1'b0};
        quo_q <= {quo_q[62:0], ge};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[src/lspf_dp.sv]
// Datapath: sums, matrix store, row permutation, multiplier, divider, result register.
`timescale 1ns / 1ps
`include "least_squares_poly_fit_assert.svh"
module lspf_dp import lspf_pkg::*; #(
  parameter int MaxDegree = MaxDegreeDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  sample_t data_i,
  output stat_t   stat_o,
  output logic    res_valid_o,
  output coef_t   res_o
);

  localparam int NPow  = 2 * MaxDegree + 1;
  localparam int NMom  = MaxDegree + 1;
  localparam int NCols = MaxDegree + 2;
  localparam int Depth = NMom * NCols;
  localparam int AW    = $clog2(Depth);
  localparam int RW    = $clog2(NMom);
  localparam int PW    = $clog2(NPow);

  logic [63:0] x_q, y_q, p_q, piv_q, term_q, v_q;
  logic [63:0] ps_q [NPow];
  logic [63:0] ms_q [NMom];
  logic [63:0] sol_q [NMom];
  logic [RW-1:0] perm_q [NMom];
  logic [RW-1:0] tmp_q;
  logic sing_q, res_valid_q;
  coef_t res_q;

  logic [RW-1:0] ii, jj, kk, prow, row_eff, sidx;
  logic [PW-1:0] pi, psi, pidx;
  logic [IdxW-1:0] col;
  logic [AW-1:0] addr;
  logic row_k, ram_re, ram_we, last_out;
  logic [63:0] rd, wdata, ps_rd, sol_rd;
  logic mul_start, div_start, mul_busy, div_busy, mul_done, div_done;
  logic [63:0] mul_a, mul_b, div_a, div_b, mres, dres;

  assign ii  = cmd_i.i[RW-1:0];
  assign jj  = cmd_i.j[RW-1:0];
  assign kk  = cmd_i.k[RW-1:0];
  assign pi  = cmd_i.i[PW-1:0];
  assign psi = PW'(cmd_i.i + cmd_i.j);
  assign last_out = (IdxW'(cmd_i.i + 1'b1) == cmd_i.m);

  // Matrix addressing through the row permutation.
  always_comb begin
    row_k = (cmd_i.op == OP_RD_KI) || (cmd_i.op == OP_RD_KJ) ||
            (cmd_i.op == OP_WR_KJ) || (cmd_i.op == OP_SWAP);
    prow    = perm_q[row_k ? kk : ii];
    row_eff = (cmd_i.op == OP_BUILD) ? ii : prow;
    case (cmd_i.op)
      OP_RD_II, OP_RD_KI: col = cmd_i.i;
      OP_RD_IM:           col = cmd_i.m;
      default:            col = cmd_i.j;
    endcase
    addr   = AW'(row_eff * NCols + col);
    ram_re = (cmd_i.op == OP_RD_II) || (cmd_i.op == OP_RD_KI) || (cmd_i.op == OP_RD_IJ) ||
             (cmd_i.op == OP_RD_KJ) || (cmd_i.op == OP_RD_IM);
    ram_we = (cmd_i.op == OP_BUILD) || (cmd_i.op == OP_WR_KJ);
    pidx   = (cmd_i.op == OP_BUILD) ? psi : pi;
    ps_rd  = ps_q[pidx];
    sidx   = (cmd_i.op == OP_MUL_BS) ? jj : ii;
    sol_rd = sol_q[sidx];
    if (cmd_i.op == OP_BUILD) begin
      wdata = (cmd_i.j == cmd_i.m) ? ms_q[ii] : ps_rd;
    end else begin
      wdata = sat_sub(rd, mres);
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = p_q;
    mul_b     = x_q;
    div_start = 1'b0;
    div_a     = v_q;
    div_b     = rd;
    case (cmd_i.op)
      OP_ACC_P: begin
        mul_start = 1'b1;
        mul_b     = y_q;
      end
      OP_ACC_PX, OP_ACC_M: mul_start = 1'b1;
      OP_MUL_EL: begin
        mul_start = 1'b1;
        mul_a     = term_q;
        mul_b     = rd;
      end
      OP_MUL_BS: begin
        mul_start = 1'b1;
        mul_a     = rd;
        mul_b     = sol_rd;
      end
      OP_DIV_EL: begin
        div_start = 1'b1;
        div_a     = rd;
        div_b     = piv_q;
      end
      OP_BS_CHK: div_start = (rd != 64'd0);
      default: ;
    endcase
  end

  lspf_ram #(.Width(64), .Depth(Depth)) u_mat (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (rd)
  );

  lspf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  lspf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .res_o   (dres)
  );

  // Status back to the controller.
  always_comb begin
    stat_o.mul_done = mul_done;
    stat_o.div_done = div_done;
    stat_o.piv_less = mag64(piv_q) < mag64(rd);
    stat_o.rd_zero  = (rd == 64'd0);
    stat_o.piv_zero = (piv_q == 64'd0);
  end

  // Running sums and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NPow; n++) ps_q[n] <= 64'd0;
      for (int n = 0; n < NMom; n++) ms_q[n] <= 64'd0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.op == OP_OUT);
      case (cmd_i.op)
        OP_ACC_P, OP_ACC_PX: ps_q[pi] <= sat_add(ps_rd, p_q);
        OP_ACC_M:            ms_q[ii] <= sat_add(ms_q[ii], mres);
        OP_OUT: begin
          if (last_out) begin
            for (int n = 0; n < NPow; n++) ps_q[n] <= 64'd0;
            for (int n = 0; n < NMom; n++) ms_q[n] <= 64'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the solver.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q <= {{24{data_i.sample_x[15]}}, data_i.sample_x, 24'd0};
        y_q <= {{24{data_i.sample_y[15]}}, data_i.sample_y, 24'd0};
        p_q <= QOne;
      end
      OP_SET_P: p_q <= mres;
      OP_BUILD: begin
        perm_q[ii] <= ii;
        sing_q     <= 1'b0;
      end
      OP_PIV_LD: piv_q <= rd;
      OP_PIV_CMP: begin
        if (stat_o.piv_less) begin
          tmp_q <= prow;
          piv_q <= rd;
        end
      end
      OP_SWAP: begin
        perm_q[ii] <= prow;
        perm_q[kk] <= tmp_q;
      end
      OP_SING:  sing_q <= 1'b1;
      OP_TERM:  term_q <= dres;
      OP_V_LD:  v_q <= rd;
      OP_V_SUB: v_q <= sat_sub(v_q, mres);
      OP_BS_CHK: begin
        if (rd == 64'd0) begin
          sing_q     <= 1'b1;
          sol_q[ii]  <= 64'd0;
        end
      end
      OP_SOL: sol_q[ii] <= dres;
      OP_OUT: begin
        res_q.coef_index <= cmd_i.i[1:0];
        res_q.coef_value <= sol_rd;
        res_q.singular   <= sing_q;
        res_q.last_coef  <= last_out;
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `LSPF_ASSERT(a_res_from_out, res_valid_q |-> $past(cmd_i.op == OP_OUT), "result word without output step")
  `LSPF_ASSERT(a_units_excl, !(mul_busy && div_busy), "multiplier and divider busy together")
  `LSPF_ASSERT(a_sums_cleared, (res_valid_q && res_q.last_coef) |-> (ps_q[0] == 64'd0 && ms_q[0] == 64'd0), "sums not cleared after run")

endmodule

[src/lspf_ctrl.sv]
// Controller: sequences accumulation, matrix build, elimination, back substitution, output.
`timescale 1ns / 1ps
`include "least_squares_poly_fit_assert.svh"
module lspf_ctrl import lspf_pkg::*; #(
  parameter int MaxDegree = MaxDegreeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       last_i,
  output logic       busy_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  localparam logic [IdxW-1:0] NPowI = IdxW'(2 * MaxDegree + 1);
  localparam logic [IdxW-1:0] NMomI = IdxW'(MaxDegree + 1);
  localparam logic [IdxW-1:0] MaxI  = IdxW'(MaxDegree);

  state_e state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic last_q, last_d;
  logic [1:0] deg_q;
  logic [IdxW-1:0] dsel, mm, mlast;

  // Effective degree: zero reads as one, large values clamp.
  always_comb begin
    if (deg_q == 2'd0) begin
      dsel = IdxW'(1);
    end else if (IdxW'(deg_q) > MaxI) begin
      dsel = MaxI;
    end else begin
      dsel = IdxW'(deg_q);
    end
    mm    = IdxW'(dsel + 1'b1);
    mlast = dsel;
  end

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    last_d    = last_q;
    cmd_o.op  = OP_NOP;
    cmd_o.i   = i_q;
    cmd_o.j   = j_q;
    cmd_o.k   = k_q;
    cmd_o.m   = mm;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          last_d   = last_i;
          i_d      = '0;
          state_d  = S_ACC_ADD;
        end
      end
      S_ACC_ADD: begin
        if (i_q < NMomI) begin
          cmd_o.op = OP_ACC_P;
          state_d  = S_ACC_WY;
        end else begin
          cmd_o.op = OP_ACC_PX;
          state_d  = S_ACC_WX;
        end
      end
      S_ACC_WY: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_ACC_M;
          state_d  = S_ACC_WX;
        end
      end
      S_ACC_WX: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_SET_P;
          if (i_q == NPowI - 1'b1) begin
            i_d     = '0;
            j_d     = '0;
            state_d = last_q ? S_BUILD : S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_ACC_ADD;
          end
        end
      end
      S_BUILD: begin
        cmd_o.op = OP_BUILD;
        if (j_q == mm) begin
          j_d = '0;
          if (i_q == mlast) begin
            i_d     = '0;
            state_d = S_PV_RD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_PV_RD: begin
        cmd_o.op = OP_RD_II;
        k_d      = i_q + 1'b1;
        state_d  = S_PV_LD;
      end
      S_PV_LD: begin
        cmd_o.op = OP_PIV_LD;
        state_d  = S_PV_RK;
      end
      S_PV_RK: begin
        cmd_o.op = OP_RD_KI;
        state_d  = S_PV_CMP;
      end
      S_PV_CMP, S_SWAP: begin
        cmd_o.op = (state_q == S_SWAP) ? OP_SWAP : OP_PIV_CMP;
        if (state_q == S_PV_CMP && stat_i.piv_less) begin
          state_d = S_SWAP;
        end else if (k_q == mlast) begin
          state_d = S_EL_CHK;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_PV_RK;
        end
      end
      S_EL_CHK: begin
        if (stat_i.piv_zero) begin
          cmd_o.op = OP_SING;
          if (IdxW'(i_q + 1'b1) == mlast) begin
            i_d     = mlast;
            state_d = S_BS_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_PV_RD;
          end
        end else begin
          k_d     = i_q + 1'b1;
          state_d = S_EL_RK;
        end
      end
      S_EL_RK: begin
        cmd_o.op = OP_RD_KI;
        state_d  = S_EL_DIV;
      end
      S_EL_DIV: begin
        cmd_o.op = OP_DIV_EL;
        state_d  = S_EL_WD;
      end
      S_EL_WD: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_TERM;
          j_d      = '0;
          state_d  = S_EL_RI;
        end
      end
      S_EL_RI: begin
        cmd_o.op = OP_RD_IJ;
        state_d  = S_EL_MUL;
      end
      S_EL_MUL: begin
        cmd_o.op = OP_MUL_EL;
        state_d  = S_EL_WM;
      end
      S_EL_WM: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_RD_KJ;
          state_d  = S_EL_WR;
        end
      end
      S_EL_WR: begin
        cmd_o.op = OP_WR_KJ;
        if (j_q == mm) begin
          if (k_q == mlast) begin
            if (IdxW'(i_q + 1'b1) == mlast) begin
              i_d     = mlast;
              state_d = S_BS_RD;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = S_PV_RD;
            end
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_EL_RK;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_EL_RI;
        end
      end
      S_BS_RD: begin
        cmd_o.op = OP_RD_IM;
        j_d      = i_q + 1'b1;
        state_d  = S_BS_LV;
      end
      S_BS_LV: begin
        cmd_o.op = OP_V_LD;
        state_d  = (j_q == mm) ? S_BS_RP : S_BS_RJ;
      end
      S_BS_RJ: begin
        cmd_o.op = OP_RD_IJ;
        state_d  = S_BS_MUL;
      end
      S_BS_MUL: begin
        cmd_o.op = OP_MUL_BS;
        state_d  = S_BS_WM;
      end
      S_BS_WM: begin
        if (stat_i.mul_done) begin
          cmd_o.op = OP_V_SUB;
          j_d      = j_q + 1'b1;
          state_d  = (IdxW'(j_q + 1'b1) == mm) ? S_BS_RP : S_BS_RJ;
        end
      end
      S_BS_RP: begin
        cmd_o.op = OP_RD_II;
        state_d  = S_BS_CHK;
      end
      S_BS_CHK, S_BS_WD: begin
        if (state_q == S_BS_CHK) begin
          cmd_o.op = OP_BS_CHK;
        end else if (stat_i.div_done) begin
          cmd_o.op = OP_SOL;
        end
        if ((state_q == S_BS_CHK && !stat_i.rd_zero) ||
            (state_q == S_BS_WD && !stat_i.div_done)) begin
          state_d = S_BS_WD;
        end else if (i_q == '0) begin
          state_d = S_OUT;
        end else begin
          i_d     = i_q - 1'b1;
          state_d = S_BS_RD;
        end
      end
      S_OUT: begin
        cmd_o.op = OP_OUT;
        if (i_q == mlast) begin
          state_d = S_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, loop counters and the degree register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      last_q  <= 1'b0;
      deg_q   <= 2'd3;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        deg_q <= cfg_wdata_i;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `LSPF_ASSERT(a_accept_idle, (start_i && !busy_o) |=> (state_q == S_ACC_ADD), "word accepted but no accumulation")
  `LSPF_ASSERT(a_out_end, (state_q == S_OUT && i_q == mlast) |=> (state_q == S_IDLE), "run did not end after last coefficient")
  `LSPF_ASSERT(a_build_range, (state_q == S_BUILD) |-> (i_q <= mlast && j_q <= mm), "matrix build index out of range")

endmodule

[src/least_squares_poly_fit.sv]
// Each sample word keeps busy_o high while it is accumulated, which runs the shared
// multiplier twice for each of the first four powers and once for the rest. A last word
// then adds the solve, paced by the bit-serial divider and the matrix RAM. A new word is
// taken only while busy_o is low.
// Results appear one word per cycle for one cycle each; the receiver cannot stall.
// Reset clears the sums and sets the degree to three; no clearing pass is needed.
`timescale 1ns / 1ps
module least_squares_poly_fit import lspf_pkg::*; #(
  parameter int MaxDegree = MaxDegreeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  sample_t    data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  output logic       res_valid_o,
  output coef_t      res_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  lspf_ctrl #(.MaxDegree(MaxDegree)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_i      (data_i.last_point),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath.
  lspf_dp #(.MaxDegree(MaxDegree)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_i      (data_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[test/tb_least_squares_poly_fit.sv]
// Self-checking testbench for the least-squares polynomial fit block.
`timescale 1ns / 1ps
module tb_least_squares_poly_fit;
  import lspf_pkg::*;

  localparam int MaxDeg = 3;
  localparam int NPow = 2 * MaxDeg + 1;
  localparam int NMom = MaxDeg + 1;
  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles = 5000;
  localparam int NumRandom = 410;
  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;

  // Sender idle percentage per phase.
  localparam int PhIdleNone = 0;
  localparam int PhIdleBusy = 61;
  localparam int PhIdleBoth = 15;

  logic clk, rst_n;
  logic start, busy, cfg_we, res_valid;
  logic [1:0] cfg_wdata;
  sample_t smp;
  coef_t res;

  least_squares_poly_fit u_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .data_i(smp),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .res_valid_o(res_valid), .res_o(res)
  );

  // Predictor state.
  logic signed [63:0] pow_acc[NPow];
  logic signed [63:0] mom_acc[NMom];
  logic signed [63:0] mat[NMom][NMom+1];
  logic signed [63:0] coefs[NMom];
  logic [1:0] degree_reg;
  coef_t coef_q[$];
  int errors, mismatches, idle_cycles;
  bit done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input bit neg);
    if (neg) return m[63] ? SMin : -$signed(m);
    return m[63] ? SMax : $signed(m);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, SMax})) return SMax;
    if (s < $signed({1'b1, SMin})) return SMin;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > $signed({1'b0, SMax})) return SMax;
    if (s < $signed({1'b1, SMin})) return SMin;
    return s[63:0];
  endfunction

  // Q32.32 multiply, round half away from zero on magnitudes.
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)} + 128'h8000_0000;
    if (p[127:96] != 0) return apply_sign(64'hFFFF_FFFF_FFFF_FFFF, a[63] ^ b[63]);
    return apply_sign(p[95:32], a[63] ^ b[63]);
  endfunction

  // Q32.32 divide, truncating on magnitudes; divisor is nonzero.
  function automatic logic signed [63:0] qdiv(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [127:0] q;
    q = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
    if (q[127:64] != 0) return apply_sign(64'hFFFF_FFFF_FFFF_FFFF, a[63] ^ b[63]);
    return apply_sign(q[63:0], a[63] ^ b[63]);
  endfunction

  task automatic clear_sums();
    for (int i = 0; i < NPow; i++) pow_acc[i] = '0;
    for (int i = 0; i < NMom; i++) mom_acc[i] = '0;
  endtask

  // Accumulate one sample word; on the last word solve and queue the coefficients.
  task automatic predict_fit(input sample_t s);
    logic signed [63:0] xq, yq, pw, tmp, term, v;
    int d, m, n;
    bit sing;
    xq = 64'(s.sample_x) <<< 24;
    yq = 64'(s.sample_y) <<< 24;
    pw = 64'sh1_0000_0000;
    for (int i = 0; i < NPow; i++) begin
      pow_acc[i] = add_sat(pow_acc[i], pw);
      if (i < NMom) mom_acc[i] = add_sat(mom_acc[i], qmul(pw, yq));
      pw = qmul(pw, xq);
    end
    if (!s.last_point) return;
    d = degree_reg;
    if (d < 1) d = 1;
    if (d > MaxDeg) d = MaxDeg;
    m = d + 1;
    n = m + 1;
    sing = 1'b0;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < m; j++) mat[i][j] = pow_acc[i+j];
      mat[i][m] = mom_acc[i];
    end
    // Forward elimination with partial pivoting.
    for (int i = 0; i < m - 1; i++) begin
      for (int k = i + 1; k < m; k++) begin
        if (mag(mat[i][i]) < mag(mat[k][i])) begin
          for (int j = 0; j < n; j++) begin
            tmp = mat[i][j]; mat[i][j] = mat[k][j]; mat[k][j] = tmp;
          end
        end
      end
      if (mat[i][i] == 0) begin
        sing = 1'b1;
        continue;
      end
      for (int k = i + 1; k < m; k++) begin
        term = qdiv(mat[k][i], mat[i][i]);
        for (int j = 0; j < n; j++) mat[k][j] = sub_sat(mat[k][j], qmul(term, mat[i][j]));
      end
    end
    // Back substitution.
    for (int i = m - 1; i >= 0; i--) begin
      v = mat[i][n-1];
      for (int j = i + 1; j < m; j++) v = sub_sat(v, qmul(mat[i][j], coefs[j]));
      if (mat[i][i] == 0) begin
        sing = 1'b1;
        coefs[i] = '0;
      end else begin
        coefs[i] = qdiv(v, mat[i][i]);
      end
    end
    for (int i = 0; i < m; i++) begin
      coef_t c;
      c.coef_index = 2'(i);
      c.coef_value = coefs[i];
      c.singular = sing;
      c.last_coef = (i == m - 1);
      coef_q.push_back(c);
    end
    clear_sums();
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n && !done) begin
      if (res_valid) begin
        if (coef_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected coefficient word %p", res);
        end else begin
          coef_t e;
          e = coef_q.pop_front();
          if (res !== e) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p, got %p", e, res);
          end
        end
      end
      if (res_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Send one sample word after a random idle gap.
  task automatic send_sample(input sample_t s, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    smp <= s;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fit(s);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Wait for all coefficients plus a quiet gap, then write the degree.
  task automatic write_degree(input logic [1:0] dg);
    while (coef_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_wdata <= dg;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    degree_reg = dg;
  endtask

  function automatic sample_t mk(input logic [15:0] x, input logic [15:0] y, input bit last);
    sample_t s;
    s.sample_x = x; s.sample_y = y; s.last_point = last;
    return s;
  endfunction

  // Directed table: a point alone at the origin is a singular fit with zero coefficients.
  typedef struct {
    sample_t s;
    bit chk;
    logic signed [63:0] c0;
    bit sng;
  } row_t;

  row_t dir_rows[$];

  initial begin
    int deg_list[6];
    int idle_pct, run_len;
    errors = 0; mismatches = 0; idle_cycles = 0; done = 0;
    start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; smp = '0;
    rst_n = 1'b0;
    degree_reg = 2'd3;
    clear_sums();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows, starting at the reset degree.
    dir_rows.push_back('{mk(16'h0000, 16'h0000, 1), 1, 64'sd0, 1});
    dir_rows.push_back('{mk(16'h0100, 16'h0100, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h0200, 16'h0300, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h0300, 16'h0500, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'hFF00, 16'h0200, 1), 0, 0, 0});
    dir_rows.push_back('{mk(16'h7FFF, 16'h7FFF, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h8000, 16'h8000, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h8000, 16'h7FFF, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h7FFF, 16'h8000, 1), 0, 0, 0});
    dir_rows.push_back('{mk(16'h0100, 16'h0400, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h0100, 16'h0400, 1), 0, 0, 0});
    dir_rows.push_back('{mk(16'hFFFF, 16'hFFFF, 0), 0, 0, 0});
    dir_rows.push_back('{mk(16'h0001, 16'h0001, 1), 0, 0, 0});
    foreach (dir_rows[r]) begin
      send_sample(dir_rows[r].s, PhIdleNone);
      if (dir_rows[r].chk && (coef_q[0].coef_value !== dir_rows[r].c0 ||
                              coef_q[0].singular !== dir_rows[r].sng)) begin
        errors++;
        $display("predictor disagrees with table row %0d", r);
      end
    end

    // Degree zero is taken as one; two points on a line, then a duplicate point.
    write_degree(2'd0);
    send_sample(mk(16'h0000, 16'h0100, 0), PhIdleNone);
    send_sample(mk(16'h0100, 16'h0300, 1), PhIdleNone);
    send_sample(mk(16'h0200, 16'h0100, 0), PhIdleNone);
    send_sample(mk(16'h0200, 16'h0100, 1), PhIdleNone);
    write_degree(2'd1);
    send_sample(mk(16'h8000, 16'h7FFF, 0), PhIdleNone);
    send_sample(mk(16'h7FFF, 16'h8000, 1), PhIdleNone);

    // Random phases over several degrees and idle rates.
    deg_list = '{2, 3, 1, 0, 3, 2};
    for (int ph = 0; ph < 6; ph++) begin
      write_degree(2'(deg_list[ph]));
      case (ph % 3)
        0: idle_pct = PhIdleNone;
        1: idle_pct = PhIdleBusy;
        default: idle_pct = PhIdleBoth;
      endcase
      for (int it = 0; it < NumRandom / 6; it++) begin
        logic [15:0] rx, ry;
        bit lst;
        if (run_len == 0) run_len = $urandom_range(1, 8);
        run_len--;
        lst = (run_len == 0);
        case ($urandom_range(9))
          0: rx = 16'($urandom);
          1: rx = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          default: rx = 16'($signed($urandom_range(0, 2048)) - 1024);
        endcase
        ry = ($urandom_range(4) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(0, 4096)) - 2048);
        send_sample(mk(rx, ry, lst), idle_pct);
      end
    end
    if (run_len != 0) send_sample(mk(16'h0100, 16'h0100, 1), PhIdleNone);

    // Drain and finish.
    while (coef_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    done = 1;
    if (errors == 0 && coef_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/lspf_pkg.sv
src/lspf_ram.sv
src/lspf_mul.sv
src/lspf_div.sv
src/lspf_dp.sv
src/lspf_ctrl.sv
src/least_squares_poly_fit.sv
test/tb_least_squares_poly_fit.sv
